[rtl/priority_admission_scheduler_unit_macros.svh]
// Assertion macros shared by the scheduler RTL modules.
// No dependencies; included by the modules that carry assertions.
`ifndef PRIORITY_ADMISSION_SCHEDULER_UNIT_MACROS_SVH
`define PRIORITY_ADMISSION_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PASU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define PASU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/pasu_pkg.sv]
// Shared types, field widths and codes of the priority admission scheduler.
// No dependencies; used by the interfaces and all scheduler modules.
`default_nettype none

package pasu_pkg;

    // Field widths
    localparam int NUM_CLASSES = 7;
    localparam int OPCODE_W    = 2;
    localparam int JOB_W       = 8;
    localparam int PRI_W       = 3;
    localparam int CNT_W       = 3;
    localparam int LIMIT_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int EVENT_W     = 3;
    localparam int COUNT_W     = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SUBMIT   = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_POLL     = 2'd2
    } op_e;

    typedef enum logic [EVENT_W-1:0] {
        EV_STARTED    = 3'd0,
        EV_QUEUED     = 3'd1,
        EV_REFUSED    = 3'd2,
        EV_RELEASED   = 3'd3,
        EV_FROM_QUEUE = 3'd4,
        EV_NONE       = 3'd5
    } event_e;

    // Queue read address source
    typedef enum logic [1:0] {
        RD_HEAD      = 2'd0,
        RD_TAIL_PREV = 2'd1,
        RD_PREV2     = 2'd2
    } rd_sel_e;

    // Job reported with the event
    typedef enum logic [1:0] {
        JOB_CUR  = 2'd0,
        JOB_HEAD = 2'd1,
        JOB_NONE = 2'd2
    } job_sel_e;

    typedef logic [NUM_CLASSES-1:0][LIMIT_W-1:0] cls_vec_t;

    typedef struct packed {
        logic [NUM_CLASSES-1:0][CNT_W-1:0] cnt;
        logic [PRI_W-1:0]                  pri;
        logic [JOB_W-1:0]                  job;
    } entry_t;

    typedef struct packed {
        op_e    opcode;
        entry_t entry;
    } item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [JOB_W-1:0]   result_job;
        logic [COUNT_W-1:0] waiting_count;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     take;
        logic     give;
        logic     src_head;
        logic     walk_start;
        logic     shift;
        logic     place;
        logic     pop;
        logic     rd_en;
        rd_sel_e  rd_sel;
        logic     set_ev;
        event_e   ev;
        job_sel_e job_sel;
        logic     out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_e  op;
        logic admit_cur;
        logic admit_head;
        logic full;
        logic empty;
        logic pri_less;
        logic cnt_one;
    } status_t;

    // Every class the job uses must be strictly below its limit
    function automatic logic admissible(entry_t e, cls_vec_t in_use, cls_vec_t lim);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (e.cnt[k] != '0 && in_use[k] >= lim[k]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

[rtl/pasu_req_if.sv]
// Request channel of the scheduler: valid/ready plus one job command item.
// Depends on pasu_pkg for field widths.
`default_nettype none

interface pasu_req_if;
    logic                            valid;
    logic                            ready;
    logic [pasu_pkg::OPCODE_W-1:0]   opcode;
    logic [pasu_pkg::JOB_W-1:0]      job_id;
    logic [pasu_pkg::PRI_W-1:0]      priority_req;
    logic [pasu_pkg::CNT_W-1:0]      nop_count;
    logic [pasu_pkg::CNT_W-1:0]      bcompress_count;
    logic [pasu_pkg::CNT_W-1:0]      bdecompress_count;
    logic [pasu_pkg::CNT_W-1:0]      gcompress_count;
    logic [pasu_pkg::CNT_W-1:0]      gdecompress_count;
    logic [pasu_pkg::CNT_W-1:0]      encrypt_count;
    logic [pasu_pkg::CNT_W-1:0]      decrypt_count;

    modport source (
        output valid, opcode, job_id, priority_req, nop_count, bcompress_count,
               bdecompress_count, gcompress_count, gdecompress_count,
               encrypt_count, decrypt_count,
        input  ready
    );

    modport sink (
        input  valid, opcode, job_id, priority_req, nop_count, bcompress_count,
               bdecompress_count, gcompress_count, gdecompress_count,
               encrypt_count, decrypt_count,
        output ready
    );
endinterface

`default_nettype wire

[rtl/pasu_rsp_if.sv]
// Response channel of the scheduler: valid/ready plus one event item.
// Depends on pasu_pkg for field widths.
`default_nettype none

interface pasu_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [pasu_pkg::EVENT_W-1:0]   event_res;
    logic [pasu_pkg::JOB_W-1:0]     result_job;
    logic [pasu_pkg::COUNT_W-1:0]   waiting_count;

    modport source (
        output valid, event_res, result_job, waiting_count,
        input  ready
    );

    modport sink (
        input  valid, event_res, result_job, waiting_count,
        output ready
    );
endinterface

`default_nettype wire

[rtl/pasu_cfg_if.sv]
// Configuration write channel: valid/ready, register index and write data.
// Depends on pasu_pkg for field widths.
`default_nettype none

interface pasu_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pasu_pkg::CFG_IDX_W-1:0]   index;
    logic [pasu_pkg::LIMIT_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

[rtl/priority_admission_scheduler_unit.sv]
// Top level of the priority admission scheduler: channel ports, controller and datapath.
// Depends on pasu_pkg, the channel interfaces, pasu_ctrl and pasu_dp.
//
// Usage:
//   req carries one command item: submit a job, report a job completed, or poll
//   the wait queue head. rsp returns exactly one event item per command, in order.
//   cfg writes the seven per-class limits (index 0..6, other indexes ignored); it is
//   always ready; the user writes it only while idle, which the block does not enforce.
// Sequence from acceptance to rsp.valid:
//   submit started or refused, completion, poll of an empty queue: decide, then
//   finish; other poll: decide, head read, finish; submit queued: decide, the
//   ordered insert comparing up to QUEUE_DEPTH - 1 queue entries, one per cycle
//   through the queue memory read port, then place and finish.
//   One item is processed at a time; the next is accepted once the result
//   has entered the output register.
// Reset clears limits, class counters and the queue; req is ready at once.
// While rsp is stalled the result holds in the output register; one more item
// is accepted and processed, then held until the register frees.
`default_nettype none

module priority_admission_scheduler_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pasu_req_if.sink   req,
    pasu_rsp_if.source rsp,
    pasu_cfg_if.sink   cfg
);

    pasu_pkg::item_t   item;
    pasu_pkg::cmd_t    cmd;
    pasu_pkg::status_t sts;
    pasu_pkg::result_t res;
    logic              in_ready;
    logic              out_valid;

    // Gather the request fields into one item
    always_comb
    begin
        item.opcode       = pasu_pkg::op_e'(req.opcode);
        item.entry.job    = req.job_id;
        item.entry.pri    = req.priority_req;
        item.entry.cnt[0] = req.nop_count;
        item.entry.cnt[1] = req.bcompress_count;
        item.entry.cnt[2] = req.bdecompress_count;
        item.entry.cnt[3] = req.gcompress_count;
        item.entry.cnt[4] = req.gdecompress_count;
        item.entry.cnt[5] = req.encrypt_count;
        item.entry.cnt[6] = req.decrypt_count;
    end

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid;
    assign rsp.event_res     = res.event_res;
    assign rsp.result_job    = res.result_job;
    assign rsp.waiting_count = res.waiting_count;

    pasu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pasu_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg_we   (cfg.valid),
        .cfg_idx  (cfg.index),
        .cfg_data (cfg.data),
        .cmd      (cmd),
        .sts      (sts),
        .res      (res)
    );

endmodule

`default_nettype wire

[rtl/pasu_ctrl.sv]
// Sequencing state machine of the scheduler: decodes each item into datapath commands.
// Depends on pasu_pkg and the assertion macro header.
`default_nettype none
`include "priority_admission_scheduler_unit_macros.svh"

module pasu_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire pasu_pkg::status_t sts,
    output pasu_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_PLACE,
        S_HEAD,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Decode state and status into commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (sts.op)
                    pasu_pkg::OP_SUBMIT:
                    begin
                        if (sts.admit_cur)
                        begin
                            cmd.take    = 1'b1;
                            cmd.set_ev  = 1'b1;
                            cmd.ev      = pasu_pkg::EV_STARTED;
                            cmd.job_sel = pasu_pkg::JOB_CUR;
                            state_next  = S_FINISH;
                        end
                        else if (sts.full)
                        begin
                            cmd.set_ev  = 1'b1;
                            cmd.ev      = pasu_pkg::EV_REFUSED;
                            cmd.job_sel = pasu_pkg::JOB_CUR;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            if (sts.empty)
                            begin
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = pasu_pkg::RD_TAIL_PREV;
                                state_next = S_WALK;
                            end
                        end
                    end
                    pasu_pkg::OP_COMPLETE:
                    begin
                        cmd.give    = 1'b1;
                        cmd.set_ev  = 1'b1;
                        cmd.ev      = pasu_pkg::EV_RELEASED;
                        cmd.job_sel = pasu_pkg::JOB_CUR;
                        state_next  = S_FINISH;
                    end
                    pasu_pkg::OP_POLL:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_ev  = 1'b1;
                            cmd.ev      = pasu_pkg::EV_NONE;
                            cmd.job_sel = pasu_pkg::JOB_NONE;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = pasu_pkg::RD_HEAD;
                            state_next = S_HEAD;
                        end
                    end
                    default:
                    begin
                        cmd.set_ev  = 1'b1;
                        cmd.ev      = pasu_pkg::EV_NONE;
                        cmd.job_sel = pasu_pkg::JOB_NONE;
                        state_next  = S_FINISH;
                    end
                endcase
            end
            S_WALK:
            begin
                // Move lower-priority entries back by one until the slot is found
                if (sts.pri_less)
                begin
                    cmd.shift = 1'b1;
                    if (sts.cnt_one)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = pasu_pkg::RD_PREV2;
                    end
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place   = 1'b1;
                cmd.set_ev  = 1'b1;
                cmd.ev      = pasu_pkg::EV_QUEUED;
                cmd.job_sel = pasu_pkg::JOB_CUR;
                state_next  = S_FINISH;
            end
            S_HEAD:
            begin
                cmd.set_ev = 1'b1;
                if (sts.admit_head)
                begin
                    cmd.take     = 1'b1;
                    cmd.src_head = 1'b1;
                    cmd.pop      = 1'b1;
                    cmd.ev       = pasu_pkg::EV_FROM_QUEUE;
                    cmd.job_sel  = pasu_pkg::JOB_HEAD;
                end
                else
                begin
                    cmd.ev      = pasu_pkg::EV_NONE;
                    cmd.job_sel = pasu_pkg::JOB_NONE;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold or drop the output valid flag
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `PASU_ASSERT_NXT(a_accept_decide, clk, rst_n, in_valid && in_ready, state_reg == S_DECIDE)
    `PASU_ASSERT_NXT(a_finish_wait, clk, rst_n, state_reg == S_FINISH && out_valid_reg && !out_ready, state_reg == S_FINISH)
    `PASU_ASSERT_IMP(a_valid_from_finish, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_FINISH))

endmodule

`default_nettype wire

[rtl/pasu_dp.sv]
// Datapath of the scheduler: limits, class counters, ordered wait queue and result registers.
// Depends on pasu_pkg and the assertion macro header.
`default_nettype none
`include "priority_admission_scheduler_unit_macros.svh"

module pasu_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire pasu_pkg::item_t                  item,
    input  wire logic                             cfg_we,
    input  wire logic [pasu_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [pasu_pkg::LIMIT_W-1:0]     cfg_data,
    input  wire pasu_pkg::cmd_t                   cmd,
    output pasu_pkg::status_t                     sts,
    output pasu_pkg::result_t                     res
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int WW = LW + pasu_pkg::COUNT_W;
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [LW-1:0] FULL = LW'(QUEUE_DEPTH);

    pasu_pkg::cls_vec_t limit_reg;
    pasu_pkg::cls_vec_t use_reg, use_next;
    pasu_pkg::entry_t   cur_reg;
    pasu_pkg::op_e      op_reg;
    pasu_pkg::entry_t   rd_data_reg;
    pasu_pkg::entry_t   mem [QUEUE_DEPTH];
    pasu_pkg::entry_t   src;
    pasu_pkg::event_e   ev_reg;
    pasu_pkg::result_t  res_reg;

    logic [PW-1:0]                hd_reg, tl_reg, wp_reg;
    logic [PW-1:0]                hd_nx, tl_nx, tl_pv, wp_pv, wp_pv2, rd_addr;
    logic [LW-1:0]                len_reg, cnt_reg;
    logic [WW-1:0]                len_wide;
    logic [pasu_pkg::JOB_W-1:0]   job_reg;
    logic [pasu_pkg::LIMIT_W:0]   sum;

    // Circular pointer neighbors
    assign hd_nx  = (hd_reg == LAST) ? '0 : hd_reg + 1'b1;
    assign tl_nx  = (tl_reg == LAST) ? '0 : tl_reg + 1'b1;
    assign tl_pv  = (tl_reg == '0) ? LAST : tl_reg - 1'b1;
    assign wp_pv  = (wp_reg == '0) ? LAST : wp_reg - 1'b1;
    assign wp_pv2 = (wp_pv == '0) ? LAST : wp_pv - 1'b1;

    always_comb
    begin
        case (cmd.rd_sel)
            pasu_pkg::RD_HEAD:      rd_addr = hd_reg;
            pasu_pkg::RD_TAIL_PREV: rd_addr = tl_pv;
            pasu_pkg::RD_PREV2:     rd_addr = wp_pv2;
            default:                rd_addr = hd_reg;
        endcase
    end

    // Status back to the controller
    assign sts.op         = op_reg;
    assign sts.admit_cur  = pasu_pkg::admissible(cur_reg, use_reg, limit_reg);
    assign sts.admit_head = pasu_pkg::admissible(rd_data_reg, use_reg, limit_reg);
    assign sts.full       = (len_reg == FULL);
    assign sts.empty      = (len_reg == '0);
    assign sts.pri_less   = (rd_data_reg.pri < cur_reg.pri);
    assign sts.cnt_one    = (cnt_reg == LW'(1));

    // Take or give class slots, saturating at both ends
    assign src = cmd.src_head ? rd_data_reg : cur_reg;

    always_comb
    begin
        use_next = use_reg;
        sum      = '0;
        for (int k = 0; k < pasu_pkg::NUM_CLASSES; k++)
        begin
            if (cmd.take)
            begin
                sum = {1'b0, use_reg[k]} + (pasu_pkg::LIMIT_W + 1)'(src.cnt[k]);
                use_next[k] = sum[pasu_pkg::LIMIT_W] ? '1 : sum[pasu_pkg::LIMIT_W-1:0];
            end
            else if (cmd.give)
            begin
                if (use_reg[k] > pasu_pkg::LIMIT_W'(src.cnt[k]))
                begin
                    use_next[k] = use_reg[k] - pasu_pkg::LIMIT_W'(src.cnt[k]);
                end
                else
                begin
                    use_next[k] = '0;
                end
            end
        end
    end

    // Limits and class counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
            use_reg   <= '0;
        end
        else
        begin
            use_reg <= use_next;
            if (cfg_we && (cfg_idx < pasu_pkg::CFG_IDX_W'(pasu_pkg::NUM_CLASSES)))
            begin
                limit_reg[cfg_idx] <= cfg_data;
            end
        end
    end

    // Queue pointers, length and walk position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hd_reg  <= '0;
            tl_reg  <= '0;
            len_reg <= '0;
            wp_reg  <= '0;
            cnt_reg <= '0;
            op_reg  <= pasu_pkg::OP_SUBMIT;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg <= item.opcode;
            end
            if (cmd.walk_start)
            begin
                wp_reg  <= tl_reg;
                cnt_reg <= len_reg;
            end
            else if (cmd.shift)
            begin
                wp_reg  <= wp_pv;
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.place)
            begin
                tl_reg  <= tl_nx;
                len_reg <= len_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                hd_reg  <= hd_nx;
                len_reg <= len_reg - 1'b1;
            end
        end
    end

    // Item latch and queue storage
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg <= item.entry;
        end
        if (cmd.shift)
        begin
            mem[wp_reg] <= rd_data_reg;
        end
        else if (cmd.place)
        begin
            mem[wp_reg] <= cur_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Stage the event, then copy it with the queue length into the output register
    assign len_wide = WW'(len_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.set_ev)
        begin
            ev_reg <= cmd.ev;
            case (cmd.job_sel)
                pasu_pkg::JOB_CUR:  job_reg <= cur_reg.job;
                pasu_pkg::JOB_HEAD: job_reg <= rd_data_reg.job;
                default:            job_reg <= '0;
            endcase
        end
        if (cmd.out_load)
        begin
            res_reg.event_res     <= ev_reg;
            res_reg.result_job    <= job_reg;
            res_reg.waiting_count <= len_wide[pasu_pkg::COUNT_W-1:0];
        end
    end

    assign res = res_reg;

    `PASU_ASSERT_IMP(a_place_room, clk, rst_n, cmd.place, len_reg != FULL)
    `PASU_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.pop, len_reg != '0)
    `PASU_ASSERT_IMP(a_shift_inside, clk, rst_n, cmd.shift, cnt_reg != '0 && cnt_reg <= len_reg)
    `PASU_ASSERT_NXT(a_place_grows, clk, rst_n, cmd.place, len_reg == $past(len_reg) + 1'b1)

endmodule

`default_nettype wire
